// File: hw/rtl/dkbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkbc_pkg
// Shared widths and configuration register indexes for the delta/key byte
// cipher block and its checker.
// ----------------------------------------------------------------------------
package dkbc_pkg;

    localparam int BYTE_W     = 8;
    localparam int KEY_LEN_W  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int KEY_REG_BYTES = 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECODE_MODE    = 3'd0,
        CFG_USE_KEY        = 3'd1,
        CFG_START_ADDITION = 3'd2,
        CFG_KEY_LENGTH     = 3'd3,
        CFG_KEY_BYTES_0_7  = 3'd4,
        CFG_KEY_BYTES_8_15 = 3'd5,
        CFG_KEY_BYTES_16_23 = 3'd6,
        CFG_KEY_BYTES_24_31 = 3'd7
    } t_cfg_idx;

endpackage

// File: hw/rtl/delta_key_byte_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_key_byte_cipher
// Byte-stream scrambler: delta coding against the previous plaintext byte with
// an alternating, optionally key-weighted offset; encode or decode by config.
// ----------------------------------------------------------------------------
// The block takes one byte per clock while the output side does not stall, and
// returns one byte per byte taken, through the input and output registers. Each byte is
// captured in an input register; the offset (start addition plus an 8x8
// product with the current key byte), the delta arithmetic and the update of
// the stream state all happen in the single step from that register into the
// output register, so a byte may follow its predecessor in the very next
// cycle. Input stall rises only while both stages are full and the output is
// stalled. Configuration writes are always ready and take effect at once; they
// are meant to be done while no transaction is in flight.
module delta_key_byte_cipher
    import dkbc_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input byte channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [BYTE_W-1:0]     i_data_byte,
    input  logic                  i_start_of_stream,
    // result byte channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [BYTE_W-1:0]     o_out_byte,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    // configuration registers
    logic                 r_decode_mode;
    logic                 r_use_key;
    logic [BYTE_W-1:0]    r_start_add;
    logic [KEY_LEN_W-1:0] r_key_len;
    logic [BYTE_W-1:0]    r_key [MAX_KEY_BYTES];

    // pipeline registers
    logic                 r_s1_vld;
    logic [BYTE_W-1:0]    r_s1_data;
    logic                 r_s1_sos;
    logic                 r_out_vld;
    logic [BYTE_W-1:0]    r_out_byte;

    // stream state
    logic [BYTE_W-1:0]    r_prev;
    logic                 r_sub;
    logic [KIDX_W-1:0]    r_kidx;
    logic                 r_first;

    logic [BYTE_W-1:0]    n_prev;
    logic                 n_sub;
    logic [KIDX_W-1:0]    n_kidx;
    logic [BYTE_W-1:0]    n_out_byte;

    logic                 advance;
    logic                 in_accept;
    logic [BYTE_W-1:0]    cur_prev;
    logic                 cur_sub;
    logic [KIDX_W-1:0]    cur_kidx;
    logic                 cur_first;
    logic [KEY_LEN_W-1:0] eff_len;
    logic [KEY_LEN_W-1:0] kidx_inc;
    logic [BYTE_W-1:0]    key_byte;
    logic [2*BYTE_W-1:0]  key_prod;
    logic [BYTE_W-1:0]    offset;
    logic [BYTE_W-1:0]    delta;

    // handshake
    assign advance     = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_s1_vld && !advance;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_byte  = r_out_byte;
    assign o_cfg_ready = 1'b1;

    // scalar configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode <= 1'b0;
            r_use_key     <= 1'b0;
            r_start_add   <= '0;
            r_key_len     <= KEY_LEN_W'(1);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DECODE_MODE:    r_decode_mode <= i_cfg_data[0];
                CFG_USE_KEY:        r_use_key     <= i_cfg_data[0];
                CFG_START_ADDITION: r_start_add   <= i_cfg_data[BYTE_W-1:0];
                CFG_KEY_LENGTH:     r_key_len     <= i_cfg_data[KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // key bytes: each 64-bit key register loads eight consecutive bytes
    for (genvar b = 0; b < MAX_KEY_BYTES; b++) begin : g_key
        localparam int KREG = b / KEY_REG_BYTES;
        localparam int KPOS = b % KEY_REG_BYTES;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_key[b] <= '0;
            end else if (i_cfg_valid &&
                         i_cfg_index == CFG_IDX_W'(int'(CFG_KEY_BYTES_0_7) + KREG)) begin
                r_key[b] <= i_cfg_data[KPOS*BYTE_W +: BYTE_W];
            end
        end
    end

    // start of stream clears the state seen by this byte
    always_comb begin
        cur_prev  = r_s1_sos ? '0   : r_prev;
        cur_sub   = r_s1_sos ? 1'b0 : r_sub;
        cur_kidx  = r_s1_sos ? '0   : r_kidx;
        cur_first = r_s1_sos ? 1'b1 : r_first;
    end

    // clamp key length to 1..MAX_KEY_BYTES and step the key index
    always_comb begin
        eff_len = r_key_len;
        if (r_key_len == '0) begin
            eff_len = KEY_LEN_W'(1);
        end
        if (r_key_len > KEY_LEN_W'(MAX_KEY_BYTES)) begin
            eff_len = KEY_LEN_W'(MAX_KEY_BYTES);
        end
        kidx_inc = KEY_LEN_W'(cur_kidx) + KEY_LEN_W'(1);
        if (!r_use_key) begin
            n_kidx = cur_kidx;
        end else if (kidx_inc >= eff_len) begin
            n_kidx = '0;
        end else begin
            n_kidx = kidx_inc[KIDX_W-1:0];
        end
    end

    // offset: start addition, plus start addition times key byte when keyed
    assign key_byte = r_key[cur_kidx];
    assign key_prod = r_start_add * key_byte;
    assign offset   = r_use_key ? r_start_add + key_prod[BYTE_W-1:0] : r_start_add;

    // delta coding, modulo 256
    always_comb begin
        delta = '0;
        if (cur_first) begin
            n_sub = cur_sub;
            if (r_decode_mode) begin
                n_out_byte = r_s1_data - offset;
                n_prev     = n_out_byte;
            end else begin
                n_out_byte = r_s1_data + offset;
                n_prev     = r_s1_data;
            end
        end else begin
            n_sub = !cur_sub;
            if (r_decode_mode) begin
                delta      = cur_sub ? r_s1_data + offset : r_s1_data - offset;
                n_prev     = cur_prev + delta;
                n_out_byte = n_prev;
            end else begin
                delta      = r_s1_data - cur_prev;
                n_out_byte = cur_sub ? delta - offset : delta + offset;
                n_prev     = r_s1_data;
            end
        end
    end

    // input stage: capture a transaction whenever the stage frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_accept) begin
            r_s1_vld <= 1'b1;
        end else if (advance) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_data <= i_data_byte;
            r_s1_sos  <= i_start_of_stream;
        end
    end

    // output stage and stream state: advance together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_prev    <= '0;
            r_sub     <= 1'b0;
            r_kidx    <= '0;
            r_first   <= 1'b1;
        end else if (advance) begin
            r_out_vld <= 1'b1;
            r_prev    <= n_prev;
            r_sub     <= n_sub;
            r_kidx    <= n_kidx;
            r_first   <= 1'b0;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= n_out_byte;
        end
    end

endmodule

// File: hw/rtl/dkbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkbc_checker
// Port-level checks for the delta/key byte cipher, bound to the top level.
// ----------------------------------------------------------------------------
module dkbc_checker
    import dkbc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [BYTE_W-1:0] o_out_byte
);

    // hold a stalled result
    a_out_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result valid dropped while stalled");

    a_out_byte_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_byte))
        else $error("stalled result byte changed");

    // a result appears only after an input transaction passed both stages
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result without a preceding input transaction");

    // input back-pressure only while the output side is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while output free");

endmodule

bind delta_key_byte_cipher dkbc_checker u_dkbc_checker (.*);

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for delta_key_byte_cipher: drives byte and config
// transactions with random idling and back-pressure, predicts every output
// byte from its own copy of the stream state, and checks them in order.
// ----------------------------------------------------------------------------
import dkbc_pkg::*;

typedef logic [BYTE_W-1:0] octet_t;

// Tracks config and stream state, and holds the output bytes still owed.
class cipher_scoreboard;
    bit                  decode_mode;
    bit                  use_key;
    octet_t              start_add;
    logic [KEY_LEN_W-1:0] key_len;
    logic [63:0]         key_regs [4];
    octet_t              prev_plain;
    bit                  subtract_next;
    logic [4:0]          key_idx;
    bit                  awaiting_first;
    octet_t              owed_bytes [$];
    int                  mismatches;

    function new();
        decode_mode = 1'b0;
        use_key     = 1'b0;
        start_add   = '0;
        key_len     = 6'd1;
        foreach (key_regs[i]) key_regs[i] = '0;
        mismatches  = 0;
        clear_stream();
    endfunction

    function void clear_stream();
        prev_plain     = '0;
        subtract_next  = 1'b0;
        key_idx        = '0;
        awaiting_first = 1'b1;
    endfunction

    function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_DECODE_MODE:     decode_mode = data[0];
            CFG_USE_KEY:         use_key = data[0];
            CFG_START_ADDITION:  start_add = data[BYTE_W-1:0];
            CFG_KEY_LENGTH:      key_len = data[KEY_LEN_W-1:0];
            CFG_KEY_BYTES_0_7:   key_regs[0] = data;
            CFG_KEY_BYTES_8_15:  key_regs[1] = data;
            CFG_KEY_BYTES_16_23: key_regs[2] = data;
            CFG_KEY_BYTES_24_31: key_regs[3] = data;
            default: ;
        endcase
    endfunction

    // Offset for this byte; step the key index when the key is in use.
    function octet_t next_offset();
        octet_t kb;
        octet_t prod;
        int     sel;
        int     eff_len;
        octet_t off;
        off = start_add;
        if (use_key) begin
            sel  = int'(key_idx);
            kb   = key_regs[sel / 8][(sel % 8) * 8 +: 8];
            prod = start_add * kb;
            off  = off + prod;
            eff_len = (key_len == 0) ? 1 : ((key_len > 32) ? 32 : int'(key_len));
            sel = sel + 1;
            if (sel >= eff_len) sel = 0;
            key_idx = sel[4:0];
        end
        return off;
    endfunction

    // Predict the output byte of one accepted input transaction.
    function void note_input(octet_t data, bit sos);
        octet_t off;
        octet_t d;
        octet_t res;
        if (sos) clear_stream();
        off = next_offset();
        if (awaiting_first) begin
            if (decode_mode) begin
                res = data - off;
                prev_plain = res;
            end else begin
                res = data + off;
                prev_plain = data;
            end
            awaiting_first = 1'b0;
        end else begin
            if (decode_mode) begin
                if (subtract_next) d = data + off;
                else d = data - off;
                prev_plain = prev_plain + d;
                res = prev_plain;
            end else begin
                d = data - prev_plain;
                if (subtract_next) res = d - off;
                else res = d + off;
                prev_plain = data;
            end
            subtract_next = !subtract_next;
        end
        owed_bytes.push_back(res);
    endfunction

    // Compare one accepted output transaction with the oldest prediction.
    function void check_result(octet_t got);
        octet_t want;
        if (owed_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected out_byte %02h at %0t", got, $realtime);
        end else begin
            want = owed_bytes.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("out_byte mismatch at %0t: expected %02h, actual %02h",
                             $realtime, want, got);
            end
        end
    endfunction

    function int pending();
        return owed_bytes.size();
    endfunction
endclass

module testbench;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_LEN       = 300;
    localparam int PHASE_ITEMS    = 125;
    localparam int NUM_PHASES     = 8;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  o_in_stall;
    octet_t                in_data = '0;
    logic                  in_sos = 1'b0;
    logic                  o_out_valid;
    logic                  out_stall = 1'b0;
    octet_t                o_out_byte;
    logic                  cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int idle_run      = 0;

    cipher_scoreboard sb = new();

    delta_key_byte_cipher #(.MAX_KEY_BYTES(32)) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (o_in_stall),
        .i_data_byte       (in_data),
        .i_start_of_stream (in_sos),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_out_byte        (o_out_byte),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Sample all three channels at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) sb.check_result(o_out_byte);
            if (in_valid && !o_in_stall) sb.note_input(in_data, in_sos);
            if (cfg_valid && o_cfg_ready) sb.write_reg(t_cfg_idx'(cfg_index), cfg_data);
        end
    end

    // Output back-pressure: long hold-off when requested, else random stall.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Abort when no transaction moves for too long.
    initial begin
        while (idle_run < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                    || (cfg_valid && o_cfg_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Offer one byte and hold it until accepted, then idle at random.
    task automatic send_byte(input octet_t data, input bit sos);
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= data;
        in_sos   <= sos;
        do @(posedge i_clk); while (o_in_stall);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
    endtask

    // Drop valid and wait for every owed byte, then a short settle.
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic cfg_quiet();
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand_key();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Pick a new setting, with extremes and out-of-range key lengths.
    task automatic program_random_config();
        logic [7:0] sa;
        logic [5:0] kl;
        case ($urandom_range(0, 3))
            0: sa = 8'h00;
            1: sa = 8'hFF;
            default: sa = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 5))
            0: kl = 6'd0;
            1: kl = 6'd1;
            2: kl = 6'd32;
            3: kl = 6'($urandom_range(33, 63));
            default: kl = 6'($urandom_range(1, 32));
        endcase
        write_reg(CFG_DECODE_MODE, 64'($urandom_range(0, 1)));
        write_reg(CFG_USE_KEY, 64'($urandom_range(0, 3) != 0));
        write_reg(CFG_START_ADDITION, 64'(sa));
        write_reg(CFG_KEY_LENGTH, 64'(kl));
        write_reg(CFG_KEY_BYTES_0_7, rand_key());
        write_reg(CFG_KEY_BYTES_8_15, rand_key());
        write_reg(CFG_KEY_BYTES_16_23, rand_key());
        write_reg(CFG_KEY_BYTES_24_31, rand_key());
        cfg_quiet();
    endtask

    initial begin
        // hold reset, then release it on a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: encode with a five-byte key at the largest start addition
        write_reg(CFG_DECODE_MODE, 64'd0);
        write_reg(CFG_USE_KEY, 64'd1);
        write_reg(CFG_START_ADDITION, 64'hFF);
        write_reg(CFG_KEY_LENGTH, 64'd5);
        write_reg(CFG_KEY_BYTES_0_7, 64'h0123_4567_89AB_CDEF);
        write_reg(CFG_KEY_BYTES_8_15, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_KEY_BYTES_16_23, 64'h0000_0000_0000_0000);
        write_reg(CFG_KEY_BYTES_24_31, 64'h8040_2010_0804_0201);
        cfg_quiet();
        // first byte after reset comes without a start marker
        send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0); send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b1); send_byte(8'h00, 1'b0);
        drain();

        // switch to decode mid-stream and shorten the key below the index
        write_reg(CFG_DECODE_MODE, 64'd1);
        write_reg(CFG_KEY_LENGTH, 64'd1);
        cfg_quiet();
        send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1); send_byte(8'h00, 1'b0);
        drain();

        // zero key length acts as one
        write_reg(CFG_KEY_LENGTH, 64'd0);
        write_reg(CFG_START_ADDITION, 64'h80);
        cfg_quiet();
        send_byte(8'h12, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b0);
        drain();

        // encode, key length past the maximum, smallest nonzero start addition
        write_reg(CFG_DECODE_MODE, 64'd0);
        write_reg(CFG_KEY_LENGTH, 64'd63);
        write_reg(CFG_START_ADDITION, 64'h01);
        cfg_quiet();
        send_byte(8'h00, 1'b1); send_byte(8'hFF, 1'b0); send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0); send_byte(8'h80, 1'b0);
        drain();

        // key off
        write_reg(CFG_USE_KEY, 64'd0);
        cfg_quiet();
        send_byte(8'hFF, 1'b1); send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
        drain();

        // random phases, cycling through the idling patterns
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if ($urandom_range(0, 4) != 0) program_random_config();
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 76; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 76; end
                default: begin send_idle_pct = 21; stall_pct = 21; end
            endcase
            // long output hold-off while the sender keeps pushing
            if (ph == 4) hold_left = HOLD_LEN;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sender pause until all owed bytes are out
                if (ph == 5 && n == PHASE_ITEMS / 2) drain();
                send_byte(octet_t'($urandom_range(0, 255)),
                          (n == 0) ? 1'($urandom_range(0, 1))
                                   : ($urandom_range(0, 99) < 4));
            end
            drain();
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: delta_key_byte_cipher.f
hw/rtl/dkbc_pkg.sv
hw/rtl/delta_key_byte_cipher.sv
hw/rtl/dkbc_checker.sv
dv/testbench.sv
